FILE: src/spmf_pkg.sv
`timescale 1ns / 1ps

package spmf_pkg;

  // Default geometry
  localparam int unsigned NumLevelsDefault  = 5;
  localparam int unsigned LevelDepthDefault = 64;

  // Field widths
  localparam int unsigned IdWidth     = 32;
  localparam int unsigned LevelWidth  = 3;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned EntryWidth  = 2 * IdWidth;
  localparam int unsigned TdataWidth  = 72;

  // Operation codes (tuser of the request channel)
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes
  localparam logic [StatusWidth-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [StatusWidth-1:0] ST_BAD_LEVEL = 3'd1;
  localparam logic [StatusWidth-1:0] ST_FULL      = 3'd2;
  localparam logic [StatusWidth-1:0] ST_SERVED    = 3'd3;
  localparam logic [StatusWidth-1:0] ST_EMPTY     = 3'd4;

  // Request held between issue and the entry memory read
  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [LevelWidth-1:0]  level;
  } stage_t;

endpackage

FILE: src/spmf_entry_ram.sv
`timescale 1ns / 1ps

module spmf_entry_ram #(
  parameter int unsigned Depth = 320,
  parameter int unsigned AddrW = 9,
  parameter int unsigned DataW = 64
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/strict_priority_multi_fifo_top.sv
`timescale 1ns / 1ps

// Strict-priority queue of NUM_LEVELS FIFOs, level 1 the most urgent.
// Request channel (s_axis): tuser carries the opcode (enqueue or dequeue),
// tdata the entry id, patient id and level. An enqueue appends the pair to
// its level; a bad level is dropped and a full level rejects the request.
// A dequeue removes the head of the lowest-numbered non-empty level.
// Result channel (m_axis): one result per request, tuser the status, tdata
// the served entry id, patient id and level (zero unless served).
// Pipeline: a result passes two registers, the synchronous entry memory
// read (with the request held in the memory stage) and then the output
// register. Throughput: one request per cycle while the result channel does
// not stall; pointers and fill counts are updated at accept, so a dequeue
// right after an enqueue to the same slot reads the freshly written entry.
// Stall: a result waiting in the output register does not block the input;
// one more request is taken into the memory stage, after which s_axis_tready
// drops until m_axis_tready frees the output register.
// Reset: all levels empty, pointers at zero; the entry memory needs no
// clearing pass, so requests are taken from the first cycle after reset.
module strict_priority_multi_fifo_top #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NumLevelsDefault,
  parameter int unsigned LEVEL_DEPTH = spmf_pkg::LevelDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] entry_id, [63:32] pat_id, [66:64] level, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] served_entry_id, [63:32] served_pat_id, [66:64] served_level,
  // [71:67] zero
  output logic [71:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned PW    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned Slots = NUM_LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned IW    = spmf_pkg::IdWidth;
  localparam int unsigned EW    = spmf_pkg::EntryWidth;
  localparam int unsigned VW    = spmf_pkg::LevelWidth;
  localparam int unsigned SW    = spmf_pkg::StatusWidth;

  localparam logic [PW-1:0] PtrLast   = PW'(LEVEL_DEPTH - 1);
  localparam logic [CW-1:0] CntFull   = CW'(LEVEL_DEPTH);
  localparam logic [AW-1:0] DepthAddr = AW'(LEVEL_DEPTH);

  // Per-level state
  logic [NUM_LEVELS-1:0][PW-1:0] head_q, head_d;
  logic [NUM_LEVELS-1:0][PW-1:0] tail_q, tail_d;
  logic [NUM_LEVELS-1:0][CW-1:0] cnt_q, cnt_d;

  // Request decode
  logic           req_op;
  logic [IW-1:0]  req_eid;
  logic [IW-1:0]  req_pid;
  logic [VW-1:0]  req_lvl;
  logic           lvl_ok;
  logic [LW-1:0]  enq_idx;
  logic           enq_full;
  logic           deq_found;
  logic [LW-1:0]  deq_idx;
  logic           s_acc;
  logic           do_wr;
  logic           do_rd;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [EW-1:0]  rd_data;

  spmf_pkg::stage_t s1_d, s1_q;
  logic             s1_valid_q;
  logic             s1_go;

  logic           out_valid_q;
  logic [SW-1:0]  out_status_q;
  logic [IW-1:0]  out_eid_q;
  logic [IW-1:0]  out_pid_q;
  logic [VW-1:0]  out_lvl_q;

  assign req_op  = s_axis_tuser[0];
  assign req_eid = s_axis_tdata[31:0];
  assign req_pid = s_axis_tdata[63:32];
  assign req_lvl = s_axis_tdata[66:64];

  // Classify the enqueue level
  assign lvl_ok   = (req_lvl != '0) && ({29'b0, req_lvl} <= 32'(NUM_LEVELS));
  assign enq_idx  = LW'(req_lvl - 3'd1);
  assign enq_full = (cnt_q[enq_idx] == CntFull);

  // Find the most urgent non-empty level
  always_comb begin
    deq_found = 1'b0;
    deq_idx   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        deq_found = 1'b1;
        deq_idx   = LW'(i);
      end
    end
  end

  // Handshake and pipeline advance
  assign s1_go         = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign do_wr         = s_acc && (req_op == spmf_pkg::OP_ENQUEUE) && lvl_ok && !enq_full;
  assign do_rd         = s_acc && (req_op == spmf_pkg::OP_DEQUEUE) && deq_found;

  assign wr_addr = AW'(enq_idx) * DepthAddr + AW'(tail_q[enq_idx]);
  assign rd_addr = AW'(deq_idx) * DepthAddr + AW'(head_q[deq_idx]);

  // Status of the request and the level it serves
  always_comb begin
    s1_d.level = '0;
    if (req_op == spmf_pkg::OP_ENQUEUE) begin
      if (!lvl_ok) begin
        s1_d.status = spmf_pkg::ST_BAD_LEVEL;
      end else if (enq_full) begin
        s1_d.status = spmf_pkg::ST_FULL;
      end else begin
        s1_d.status = spmf_pkg::ST_ENQUEUED;
      end
    end else if (deq_found) begin
      s1_d.status = spmf_pkg::ST_SERVED;
      s1_d.level  = VW'(32'(deq_idx) + 32'd1);
    end else begin
      s1_d.status = spmf_pkg::ST_EMPTY;
    end
  end

  // Advance pointers and fill counts
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      tail_d[enq_idx] = (tail_q[enq_idx] == PtrLast) ? '0 : tail_q[enq_idx] + 1'b1;
      cnt_d[enq_idx]  = cnt_q[enq_idx] + 1'b1;
    end
    if (do_rd) begin
      head_d[deq_idx] = (head_q[deq_idx] == PtrLast) ? '0 : head_q[deq_idx] + 1'b1;
      cnt_d[deq_idx]  = cnt_q[deq_idx] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  spmf_entry_ram #(
    .Depth (Slots),
    .AddrW (AW),
    .DataW (EW)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (do_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i ({req_eid, req_pid}),
    .rd_en_i   (do_rd),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Hold the request while the memory read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= s1_d;
    end
  end

  // Output register, zero fields unless served
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_valid_q) begin
      out_status_q <= s1_q.status;
      out_lvl_q    <= s1_q.level;
      if (s1_q.status == spmf_pkg::ST_SERVED) begin
        out_eid_q <= rd_data[EW-1:IW];
        out_pid_q <= rd_data[IW-1:0];
      end else begin
        out_eid_q <= '0;
        out_pid_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'b0, out_lvl_q, out_pid_q, out_eid_q};

  // Assertions

  // A served dequeue reaches the memory stage as served on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rd |=> s1_valid_q && (s1_q.status == spmf_pkg::ST_SERVED))
    else $error("served dequeue lost before memory stage");

  // Results other than served carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != spmf_pkg::ST_SERVED)
      |-> (out_eid_q == '0) && (out_pid_q == '0) && (out_lvl_q == '0))
    else $error("non-served result with nonzero fields");

  // A served result names a real level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == spmf_pkg::ST_SERVED) |-> (out_lvl_q != '0))
    else $error("served result without level");

  // Pointers of an empty level meet, fill counts stay in range
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q[g] == '0) |-> (head_q[g] == tail_q[g]))
      else $error("empty level with diverged pointers");
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] <= CntFull)
      else $error("fill count beyond level depth");
  end

endmodule

FILE: sim/strict_priority_multi_fifo_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the priority queue, keeps its own copy of the
// level FIFOs and checks every result against the outcome of its request.
module strict_priority_multi_fifo_checker #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NumLevelsDefault,
  parameter int unsigned LEVEL_DEPTH = spmf_pkg::LevelDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_tvalid_i,
  input  logic        req_tready_i,
  // [31:0] entry_id, [63:32] pat_id, [66:64] level, [71:67] zero
  input  logic [71:0] req_tdata_i,
  // [0] opcode
  input  logic [0:0]  req_tuser_i,
  input  logic        rsp_tvalid_i,
  input  logic        rsp_tready_i,
  // [31:0] served_entry_id, [63:32] served_pat_id, [66:64] served_level,
  // [71:67] zero
  input  logic [71:0] rsp_tdata_i,
  // [2:0] status
  input  logic [2:0]  rsp_tuser_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  localparam int PrintCap = 50;

  typedef struct packed {
    logic [spmf_pkg::StatusWidth-1:0] status;
    logic [spmf_pkg::IdWidth-1:0]     entry_id;
    logic [spmf_pkg::IdWidth-1:0]     pat_id;
    logic [spmf_pkg::LevelWidth-1:0]  level;
  } queue_result_t;

  // Shadow FIFOs: {entry_id, pat_id} per slot
  logic [spmf_pkg::EntryWidth-1:0] level_slots [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned                     rd_slot [NUM_LEVELS];
  int unsigned                     wr_slot [NUM_LEVELS];
  int unsigned                     held    [NUM_LEVELS];

  queue_result_t awaited_results [$];
  queue_result_t oldest;
  queue_result_t fresh;
  int            mismatches;

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= LEVEL_DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one request to the shadow FIFOs and return its outcome
  function automatic queue_result_t serve_request(logic op,
                                                  logic [spmf_pkg::IdWidth-1:0] eid,
                                                  logic [spmf_pkg::IdWidth-1:0] pid,
                                                  logic [spmf_pkg::LevelWidth-1:0] lvl);
    queue_result_t                   res;
    int                              q;
    bit                              found;
    logic [spmf_pkg::EntryWidth-1:0] word;
    res   = '0;
    found = 1'b0;
    if (op == spmf_pkg::OP_ENQUEUE) begin
      if (lvl < 1 || lvl > NUM_LEVELS) begin
        res.status = spmf_pkg::ST_BAD_LEVEL;
      end else begin
        q = int'(lvl) - 1;
        if (held[q] >= LEVEL_DEPTH) begin
          res.status = spmf_pkg::ST_FULL;
        end else begin
          level_slots[q][wr_slot[q]] = {eid, pid};
          wr_slot[q] = next_slot(wr_slot[q]);
          held[q]++;
          res.status = spmf_pkg::ST_ENQUEUED;
        end
      end
    end else begin
      res.status = spmf_pkg::ST_EMPTY;
      // Serve the lowest-numbered level that holds anything
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (!found && held[i] != 0) begin
          found        = 1'b1;
          word         = level_slots[i][rd_slot[i]];
          rd_slot[i]   = next_slot(rd_slot[i]);
          held[i]--;
          res.status   = spmf_pkg::ST_SERVED;
          res.entry_id = word[spmf_pkg::EntryWidth-1:spmf_pkg::IdWidth];
          res.pat_id   = word[spmf_pkg::IdWidth-1:0];
          res.level    = spmf_pkg::LevelWidth'(i + 1);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [spmf_pkg::IdWidth-1:0] got,
                                 logic [spmf_pkg::IdWidth-1:0] want);
    if (mismatches < PrintCap) begin
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Check results against the oldest outcome, then record new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_slot[i] = 0;
        wr_slot[i] = 0;
        held[i]    = 0;
      end
      awaited_results.delete();
      mismatches       = 0;
      outstanding_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (rsp_tvalid_i && rsp_tready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", rsp_tuser_i, '0);
        end else begin
          oldest = awaited_results[0];
          awaited_results.delete(0);
          if (rsp_tuser_i != oldest.status)
            report_mismatch("status", rsp_tuser_i, oldest.status);
          if (rsp_tdata_i[31:0] != oldest.entry_id)
            report_mismatch("served_entry_id", rsp_tdata_i[31:0], oldest.entry_id);
          if (rsp_tdata_i[63:32] != oldest.pat_id)
            report_mismatch("served_pat_id", rsp_tdata_i[63:32], oldest.pat_id);
          if (rsp_tdata_i[66:64] != oldest.level)
            report_mismatch("served_level", rsp_tdata_i[66:64], oldest.level);
        end
      end
      if (req_tvalid_i && req_tready_i) begin
        fresh = serve_request(req_tuser_i[0], req_tdata_i[31:0],
                              req_tdata_i[63:32], req_tdata_i[66:64]);
        awaited_results.insert(awaited_results.size(), fresh);
      end
      outstanding_o    <= awaited_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: sim/strict_priority_multi_fifo_top_test.sv
`timescale 1ns / 1ps

// Drives requests into the priority queue, stalls its result channel and
// gives the verdict from the checker's mismatch count.
module strict_priority_multi_fifo_top_test;

  localparam int RandomItems   = 500;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PULSED,
    RX_SPARSE_STALL
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int mismatch_count;
  int outstanding;
  int sent_count  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  rx_mode_e rx_mode   = RX_OPEN;
  int       rx_left   = 0;

  strict_priority_multi_fifo_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  strict_priority_multi_fifo_checker queue_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_tvalid_i     (s_axis_tvalid),
    .req_tready_i     (s_axis_tready),
    .req_tdata_i      (s_axis_tdata),
    .req_tuser_i      (s_axis_tuser),
    .rsp_tvalid_i     (m_axis_tvalid),
    .rsp_tready_i     (m_axis_tready),
    .rsp_tdata_i      (m_axis_tdata),
    .rsp_tuser_i      (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: switch at random between stall patterns
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:         m_axis_tready <= 1'b1;
      RX_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PULSED:       m_axis_tready <= (rx_left % 8) < 3;
      RX_SPARSE_STALL: m_axis_tready <= $urandom_range(0, 9) != 0;
      default:         m_axis_tready <= 1'b1;
    endcase
  end

  // Hold one request until accepted; sometimes insert a gap between bursts
  task automatic send_request(logic op, logic [spmf_pkg::IdWidth-1:0] eid,
                              logic [spmf_pkg::IdWidth-1:0] pid,
                              logic [spmf_pkg::LevelWidth-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, lvl, pid, eid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  // Mostly valid levels, now and then one outside 1..5
  function automatic logic [spmf_pkg::LevelWidth-1:0] pick_level();
    logic [spmf_pkg::LevelWidth-1:0] lvl;
    if ($urandom_range(0, 99) < 85) begin
      lvl = spmf_pkg::LevelWidth'($urandom_range(1, spmf_pkg::NumLevelsDefault));
    end else begin
      case ($urandom_range(0, 2))
        0:       lvl = 3'd0;
        1:       lvl = 3'd6;
        default: lvl = 3'd7;
      endcase
    end
    return lvl;
  endfunction

  task automatic send_dequeue();
    send_request(spmf_pkg::OP_DEQUEUE, $urandom, $urandom,
                 spmf_pkg::LevelWidth'($urandom));
  endtask

  // Push one level past full, then drain everything and more
  task automatic fill_and_drain();
    logic [spmf_pkg::LevelWidth-1:0] lvl;
    int                              n;
    lvl = spmf_pkg::LevelWidth'($urandom_range(1, spmf_pkg::NumLevelsDefault));
    n   = spmf_pkg::LevelDepthDefault + $urandom_range(1, 4);
    repeat (n) send_request(spmf_pkg::OP_ENQUEUE, $urandom, $urandom, lvl);
    repeat (n + $urandom_range(0, 6)) send_dequeue();
  endtask

  task automatic mixed_run(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 55)
        send_request(spmf_pkg::OP_ENQUEUE, $urandom, $urandom, pick_level());
      else
        send_dequeue();
    end
  endtask

  // Stop the run if nothing moves on either channel for too long
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int segment;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue with junk operands, then bad levels
    send_request(spmf_pkg::OP_DEQUEUE, '1, '1, 3'd7);
    send_request(spmf_pkg::OP_ENQUEUE, 32'h0000_0001, 32'h0000_0002, 3'd0);
    send_request(spmf_pkg::OP_ENQUEUE, '1, '1, 3'd6);
    send_request(spmf_pkg::OP_ENQUEUE, '0, '0, 3'd7);
    // Field extremes across levels, served in priority order
    send_request(spmf_pkg::OP_ENQUEUE, '0, '0, 3'd5);
    send_request(spmf_pkg::OP_ENQUEUE, '1, '1, 3'd5);
    send_request(spmf_pkg::OP_ENQUEUE, '1, '0, 3'd3);
    send_request(spmf_pkg::OP_ENQUEUE, '0, '1, 3'd1);
    send_request(spmf_pkg::OP_ENQUEUE, $urandom, $urandom, 3'd2);
    send_request(spmf_pkg::OP_ENQUEUE, $urandom, $urandom, 3'd4);
    repeat (7) send_dequeue();
    // Dequeue right behind an enqueue into the same slot
    send_request(spmf_pkg::OP_ENQUEUE, $urandom, $urandom, 3'd1);
    send_dequeue();

    segment = 0;
    while (sent_count < RandomItems) begin
      if (segment % 4 == 0)
        fill_and_drain();
      else
        mixed_run(20);
      segment++;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
